[rtl/core/nps_pkg.sv]
// ---------------------------------------------------------------------------
// nps_pkg - shared types and constants for the nearest point search core
// Table sizes, coordinate widths, action and status codes, point layout.
// ---------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

    // Table geometry
    localparam int MAX_POINTS  = 16;
    localparam int STORE_DEPTH = 2 * MAX_POINTS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);

    // Arithmetic widths
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;

    // Action codes
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Stored point, y in the upper half
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    // Control tag that travels with each point through the distance pipe
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } dist_tag_t;

endpackage

`default_nettype wire

[rtl/core/nps_stream_if.sv]
// ---------------------------------------------------------------------------
// nps_stream_if - valid/ready channels of the nearest point search core
// Input word: action, team, position. Output word: nearest point, status.
// ---------------------------------------------------------------------------
`default_nettype none

interface nps_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          action;
    logic                                team;
    logic signed [nps_pkg::COORD_W-1:0]  pos_x;
    logic signed [nps_pkg::COORD_W-1:0]  pos_y;

    modport source (output valid, action, team, pos_x, pos_y, input ready);
    modport sink   (input valid, action, team, pos_x, pos_y, output ready);
endinterface

interface nps_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [nps_pkg::COORD_W-1:0]  near_x;
    logic signed [nps_pkg::COORD_W-1:0]  near_y;
    logic [1:0]                          status;

    modport source (output valid, near_x, near_y, status, input ready);
    modport sink   (input valid, near_x, near_y, status, output ready);
endinterface

`default_nettype wire

[rtl/core/nps_point_mem.sv]
// ---------------------------------------------------------------------------
// nps_point_mem - point store for both teams
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module nps_point_mem (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [nps_pkg::ADDR_W-1:0]   waddr,
    input  wire nps_pkg::point_t              wdata,
    input  wire logic [nps_pkg::ADDR_W-1:0]   raddr,
    output nps_pkg::point_t                   rdata
);

    nps_pkg::point_t mem [nps_pkg::STORE_DEPTH];
    nps_pkg::point_t rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/nps_dist_unit.sv]
// ---------------------------------------------------------------------------
// nps_dist_unit - squared distance pipeline
// Three stages: absolute differences, squares, sum. Takes one point per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module nps_dist_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire nps_pkg::dist_tag_t                  tag_in,
    input  wire logic signed [nps_pkg::COORD_W-1:0]  qx,
    input  wire logic signed [nps_pkg::COORD_W-1:0]  qy,
    input  wire nps_pkg::point_t                     pt_in,
    output nps_pkg::dist_tag_t                       tag_out,
    output nps_pkg::point_t                          pt_out,
    output logic [nps_pkg::DIST_W-1:0]               dist_sq
);

    nps_pkg::dist_tag_t tag1_reg, tag2_reg, tag3_reg;
    nps_pkg::point_t    pt1_reg, pt2_reg, pt3_reg;
    logic [nps_pkg::COORD_W-1:0] dx_reg, dy_reg;
    logic [nps_pkg::SQ_W-1:0]    sqx_reg, sqy_reg;
    logic [nps_pkg::DIST_W-1:0]  dist_reg;

    logic signed [nps_pkg::DIFF_W-1:0] diff_x, diff_y, neg_x, neg_y;
    logic [nps_pkg::COORD_W-1:0] dx_next, dy_next;

    // Absolute difference; magnitude always fits in a coordinate width
    always_comb
    begin
        diff_x  = nps_pkg::DIFF_W'(qx) - nps_pkg::DIFF_W'(pt_in.x);
        diff_y  = nps_pkg::DIFF_W'(qy) - nps_pkg::DIFF_W'(pt_in.y);
        neg_x   = -diff_x;
        neg_y   = -diff_y;
        dx_next = diff_x[nps_pkg::DIFF_W-1] ? neg_x[nps_pkg::COORD_W-1:0]
                                            : diff_x[nps_pkg::COORD_W-1:0];
        dy_next = diff_y[nps_pkg::DIFF_W-1] ? neg_y[nps_pkg::COORD_W-1:0]
                                            : diff_y[nps_pkg::COORD_W-1:0];
    end

    // Tag valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        pt1_reg  <= pt_in;
        sqx_reg  <= nps_pkg::SQ_W'(dx_reg) * nps_pkg::SQ_W'(dx_reg);
        sqy_reg  <= nps_pkg::SQ_W'(dy_reg) * nps_pkg::SQ_W'(dy_reg);
        pt2_reg  <= pt1_reg;
        dist_reg <= nps_pkg::DIST_W'(sqx_reg) + nps_pkg::DIST_W'(sqy_reg);
        pt3_reg  <= pt2_reg;
    end

    assign tag_out = tag3_reg;
    assign pt_out  = pt3_reg;
    assign dist_sq = dist_reg;

endmodule

`default_nettype wire

[rtl/core/nearest_point_search_core.sv]
// Flow: add, clear, unused code and empty query go from idle straight to the done state,
//   which loads the result word into the output register; a query passes the scan state first.
// A new input word is taken only in the idle state, once the last result word is loaded;
//   a query walks the store one point per cycle through the distance pipe;
//   a stalled result word holds the sequencer in its done state.
// Reset: asynchronous, active low; both counts clear, store contents stay undefined.
// ---------------------------------------------------------------------------
// nearest_point_search_core - two point tables with nearest point query
// Sequencer, per-team counts, output register; store and distance pipe below.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_point_search_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    nps_in_if.sink      item,
    nps_out_if.source   result
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t state_reg;
    logic [nps_pkg::CNT_W-1:0]   cnt_a_reg, cnt_b_reg, scan_n_reg, idx_reg;
    logic                        issuing_reg, team_reg;
    nps_pkg::dist_tag_t          rd_tag_reg;
    logic [nps_pkg::DIST_W-1:0]  best_d_reg;
    nps_pkg::point_t             best_p_reg;
    logic signed [nps_pkg::COORD_W-1:0] qx_reg, qy_reg;
    logic signed [nps_pkg::COORD_W-1:0] res_x_reg, res_y_reg, out_x_reg, out_y_reg;
    logic [1:0]                  res_st_reg, out_st_reg;
    logic                        out_valid_reg;

    logic                        accept, full, take, wr_en;
    logic [nps_pkg::CNT_W-1:0]   cnt_sel;
    logic [nps_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
    nps_pkg::point_t             wr_pt, rd_pt, d_pt;
    nps_pkg::dist_tag_t          d_tag;
    logic [nps_pkg::DIST_W-1:0]  d_dist;

    // Handshake and table selection
    always_comb
    begin
        accept  = item.valid && (state_reg == S_IDLE);
        cnt_sel = item.team ? cnt_b_reg : cnt_a_reg;
        full    = (cnt_sel == nps_pkg::CNT_W'(nps_pkg::MAX_POINTS));
        wr_en   = accept && (item.action == nps_pkg::ACT_ADD) && !full;
        wr_addr = (item.team ? nps_pkg::ADDR_W'(nps_pkg::MAX_POINTS) : '0)
                  + nps_pkg::ADDR_W'(cnt_sel);
        rd_addr = (team_reg ? nps_pkg::ADDR_W'(nps_pkg::MAX_POINTS) : '0)
                  + nps_pkg::ADDR_W'(idx_reg);
        wr_pt.x = item.pos_x;
        wr_pt.y = item.pos_y;
        take    = d_tag.first || (d_dist < best_d_reg);
    end

    nps_point_mem u_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_pt),
        .raddr (rd_addr),
        .rdata (rd_pt)
    );

    nps_dist_unit u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (rd_tag_reg),
        .qx      (qx_reg),
        .qy      (qy_reg),
        .pt_in   (rd_pt),
        .tag_out (d_tag),
        .pt_out  (d_pt),
        .dist_sq (d_dist)
    );

    // Query word held for the scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            team_reg <= item.team;
            qx_reg   <= item.pos_x;
            qy_reg   <= item.pos_y;
        end
    end

    // Sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            scan_n_reg    <= '0;
            idx_reg       <= '0;
            issuing_reg   <= 1'b0;
            rd_tag_reg    <= '0;
            best_d_reg    <= '0;
            best_p_reg    <= '0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
            res_st_reg    <= nps_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_st_reg    <= nps_pkg::ST_OK;
        end
        else
        begin
            rd_tag_reg <= '0;
            if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_x_reg  <= '0;
                        res_y_reg  <= '0;
                        res_st_reg <= nps_pkg::ST_OK;
                        state_reg  <= S_DONE;
                        unique case (item.action)
                            nps_pkg::ACT_ADD:
                            begin
                                if (full)
                                begin
                                    res_st_reg <= nps_pkg::ST_FULL;
                                end
                                else if (item.team)
                                begin
                                    cnt_b_reg <= cnt_b_reg + 1'b1;
                                end
                                else
                                begin
                                    cnt_a_reg <= cnt_a_reg + 1'b1;
                                end
                            end
                            nps_pkg::ACT_QUERY:
                            begin
                                if (cnt_sel == '0)
                                begin
                                    res_st_reg <= nps_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    scan_n_reg  <= cnt_sel;
                                    idx_reg     <= '0;
                                    issuing_reg <= 1'b1;
                                    state_reg   <= S_SCAN;
                                end
                            end
                            nps_pkg::ACT_CLEAR:
                            begin
                                cnt_a_reg <= '0;
                                cnt_b_reg <= '0;
                            end
                            default:
                            begin
                                res_st_reg <= nps_pkg::ST_OK;
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    // issue one store read per cycle
                    if (issuing_reg)
                    begin
                        rd_tag_reg.valid <= 1'b1;
                        rd_tag_reg.first <= (idx_reg == '0);
                        rd_tag_reg.last  <= ((idx_reg + 1'b1) == scan_n_reg);
                        idx_reg          <= idx_reg + 1'b1;
                        if ((idx_reg + 1'b1) == scan_n_reg)
                        begin
                            issuing_reg <= 1'b0;
                        end
                    end
                    // keep the first of the least distances
                    if (d_tag.valid)
                    begin
                        if (take)
                        begin
                            best_d_reg <= d_dist;
                            best_p_reg <= d_pt;
                        end
                        if (d_tag.last)
                        begin
                            res_x_reg  <= take ? d_pt.x : best_p_reg.x;
                            res_y_reg  <= take ? d_pt.y : best_p_reg.y;
                            res_st_reg <= nps_pkg::ST_OK;
                            state_reg  <= S_DONE;
                        end
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= res_x_reg;
                        out_y_reg     <= res_y_reg;
                        out_st_reg    <= res_st_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item.ready    = (state_reg == S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.near_x = out_x_reg;
    assign result.near_y = out_y_reg;
    assign result.status = out_st_reg;

endmodule

`default_nettype wire

[rtl/core/nps_checker.sv]
// ---------------------------------------------------------------------------
// nps_checker - port level checks for the nearest point search core
// Result word handshake, one word in flight, status and payload consistency.
// ---------------------------------------------------------------------------
`default_nettype none

module nps_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                item_valid,
    input wire logic                                item_ready,
    input wire logic                                result_valid,
    input wire logic                                result_ready,
    input wire logic signed [nps_pkg::COORD_W-1:0]  near_x,
    input wire logic signed [nps_pkg::COORD_W-1:0]  near_y,
    input wire logic [1:0]                          status
);

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(near_x) && $stable(near_y)
            && $stable(status))
        else $error("result payload changed while stalled");

    // One word at a time: not ready right after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input taken while a word is in work");

    // Only the defined status codes appear
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == nps_pkg::ST_OK) || (status == nps_pkg::ST_EMPTY)
            || (status == nps_pkg::ST_FULL))
        else $error("undefined status code");

    // Empty and full results carry a zero point
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != nps_pkg::ST_OK) |-> (near_x == '0) && (near_y == '0))
        else $error("nonzero point with error status");

endmodule

bind nearest_point_search_core nps_checker u_nps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .near_x       (result.near_x),
    .near_y       (result.near_y),
    .status       (result.status)
);

`default_nettype wire

[tb/sv/nearest_point_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// nearest_point_checker - result predictor and comparator for the core
// Watches both channels. Every word taken on the input updates a private copy
// of the two point tables and queues the expected result word. Every word
// taken on the output is compared field by field with the oldest one queued.
// ---------------------------------------------------------------------------

module nearest_point_checker (
    input  logic clk,
    input  logic rst_n,
    nps_in_if    item,
    nps_out_if   result,
    output int   fail_count,
    output int   pending
);
    import nps_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [1:0]                status;
    } near_word_t;

    point_t      team_points [2][MAX_POINTS];
    int unsigned team_count [2];
    near_word_t  awaited_words [$];

    // Squared Euclidean distance, exact in 64 bits
    function automatic longint sq_distance(point_t p, logic signed [COORD_W-1:0] qx,
                                           logic signed [COORD_W-1:0] qy);
        longint dx;
        longint dy;
        dx = longint'(p.x) - longint'(qx);
        dy = longint'(p.y) - longint'(qy);
        return dx * dx + dy * dy;
    endfunction

    // Apply one input word to the table copy and return the word it should produce
    function automatic near_word_t predict_nearest(logic [1:0] act, logic tm,
                                                   logic signed [COORD_W-1:0] px,
                                                   logic signed [COORD_W-1:0] py);
        near_word_t w;
        point_t     p;
        longint     best_d;
        longint     d;
        int         i;
        w      = '0;
        p.x    = px;
        p.y    = py;
        best_d = 0;
        case (act)
            ACT_ADD:
            begin
                if (team_count[tm] >= MAX_POINTS)
                    w.status = ST_FULL;
                else
                begin
                    team_points[tm][team_count[tm]] = p;
                    team_count[tm]++;
                end
            end
            ACT_QUERY:
            begin
                if (team_count[tm] == 0)
                    w.status = ST_EMPTY;
                else
                begin
                    // strict less-than keeps the earliest point on a tie
                    for (i = 0; i < team_count[tm]; i++)
                    begin
                        d = sq_distance(team_points[tm][i], px, py);
                        if (i == 0 || d < best_d)
                        begin
                            best_d = d;
                            w.x    = team_points[tm][i].x;
                            w.y    = team_points[tm][i].y;
                        end
                    end
                end
            end
            ACT_CLEAR:
            begin
                team_count[0] = 0;
                team_count[1] = 0;
            end
            default: ;
        endcase
        return w;
    endfunction

    // Monitor: predict on input words, compare on output words
    always @(posedge clk)
    begin
        near_word_t want;
        if (!rst_n)
        begin
            team_count[0] = 0;
            team_count[1] = 0;
            awaited_words.delete();
            fail_count = 0;
        end
        else
        begin
            if (item.valid && item.ready)
                awaited_words.push_back(predict_nearest(item.action, item.team,
                                                        item.pos_x, item.pos_y));
            if (result.valid && result.ready)
            begin
                if (awaited_words.size() == 0)
                begin
                    $error("result word with none expected: near_x %0d near_y %0d status %0d",
                           result.near_x, result.near_y, result.status);
                    fail_count++;
                end
                else
                begin
                    want = awaited_words.pop_front();
                    if (result.near_x !== want.x)
                    begin
                        $error("near_x mismatch: expected %0d, got %0d", want.x, result.near_x);
                        fail_count++;
                    end
                    if (result.near_y !== want.y)
                    begin
                        $error("near_y mismatch: expected %0d, got %0d", want.y, result.near_y);
                        fail_count++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.status,
                               result.status);
                        fail_count++;
                    end
                end
            end
        end
        pending = awaited_words.size();
    end

endmodule

[tb/sv/nearest_point_search_core_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// nearest_point_search_core_test - stimulus and verdict for the core
// Directed words cover empty and full tables, ties, extreme coordinates, the
// unused action code and clear. Random clear-led sequences of adds and queries
// follow under four idle/stall mixes, with one long output hold-off.
// ---------------------------------------------------------------------------

module nearest_point_search_core_test;
    import nps_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int WORDS_PER_PHASE = 440;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_EDGE} spread_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   hold_left;
    bit   hold_request;
    bit   hold_done;

    nps_in_if  item_ch ();
    nps_out_if result_ch ();

    nearest_point_search_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    nearest_point_checker nearest_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("nearest_point_search_core_test failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        hold_left = 0;
        hold_done = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offer one word, with random idle cycles ahead of it
    task automatic send_word(logic [1:0] act, logic tm, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.action <= act;
        item_ch.team   <= tm;
        item_ch.pos_x  <= x;
        item_ch.pos_y  <= y;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(spread_t spread);
        logic signed [COORD_W-1:0] c;
        case (spread)
            SPREAD_NEAR: c = COORD_W'(int'($urandom_range(8)) - 4);
            SPREAD_EDGE:
            begin
                case ($urandom_range(6))
                    0: c = COORD_MIN;
                    1: c = COORD_MIN + COORD_W'(1);
                    2: c = '1;
                    3: c = '0;
                    4: c = COORD_W'(1);
                    5: c = COORD_MAX - COORD_W'(1);
                    default: c = COORD_MAX;
                endcase
            end
            default: c = COORD_W'($urandom_range(24'hFFFFFF));
        endcase
        return c;
    endfunction

    task automatic run_directed();
        int i;
        send_word(ACT_QUERY, 1'b0, '0, '0);                    // empty table
        send_word(ACT_QUERY, 1'b1, COORD_MAX, COORD_MIN);
        send_word(ACT_ADD, 1'b0, COORD_MAX, COORD_MAX);
        send_word(ACT_ADD, 1'b0, COORD_MIN, COORD_MIN);
        send_word(ACT_QUERY, 1'b0, COORD_MIN, COORD_MAX);      // tie at the widest reach
        send_word(ACT_QUERY, 1'b0, COORD_MIN + COORD_W'(1), COORD_MIN);
        send_word(ACT_ADD, 1'b1, COORD_W'(10), '0);
        send_word(ACT_ADD, 1'b1, COORD_W'(-10), '0);
        send_word(ACT_QUERY, 1'b1, '0, '0);                    // tie, earliest wins
        send_word(ACT_UNUSED, 1'b1, COORD_MAX, COORD_MIN);
        send_word(ACT_CLEAR, 1'b1, COORD_MIN, COORD_MAX);
        send_word(ACT_QUERY, 1'b0, COORD_W'(5), COORD_W'(5));  // empty after clear
        // fill one table, then overflow it
        for (i = 0; i < MAX_POINTS; i++)
            send_word(ACT_ADD, 1'b1, COORD_W'(i * 1000 - 8000), COORD_W'(-i * 777));
        send_word(ACT_ADD, 1'b1, COORD_W'(3), COORD_W'(3));
        send_word(ACT_QUERY, 1'b1, COORD_MAX, COORD_MAX);
    endtask

    // Clear-led sequences of adds and queries, a little noise mixed in
    task automatic run_random(int word_total);
        int      sent;
        int      seq_len;
        int      roll;
        int      i;
        spread_t spread;
        spread_t s;
        sent = 0;
        while (sent < word_total)
        begin
            spread  = spread_t'($urandom_range(2));
            seq_len = $urandom_range(70, 4);
            send_word(ACT_CLEAR, 1'($urandom_range(1)), pick_coord(SPREAD_FULL),
                      pick_coord(SPREAD_FULL));
            sent++;
            for (i = 0; i < seq_len && sent < word_total; i++)
            begin
                roll = $urandom_range(99);
                s    = ($urandom_range(9) == 0) ? SPREAD_FULL : spread;
                if (roll < 46)
                    send_word(ACT_ADD, 1'($urandom_range(1)), pick_coord(s), pick_coord(s));
                else if (roll < 96)
                    send_word(ACT_QUERY, 1'($urandom_range(1)), pick_coord(s),
                              pick_coord(s));
                else if (roll < 98)
                    send_word(ACT_UNUSED, 1'($urandom_range(1)), pick_coord(SPREAD_FULL),
                              pick_coord(SPREAD_FULL));
                else
                    send_word(ACT_CLEAR, 1'($urandom_range(1)), pick_coord(SPREAD_FULL),
                              pick_coord(SPREAD_FULL));
                sent++;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        int phase;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b0;
        rst_n          <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.action <= ACT_ADD;
        item_ch.team   <= 1'b0;
        item_ch.pos_x  <= '0;
        item_ch.pos_y  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    hold_request       = 1'b1;   // output held off, input backs up
                end
                1:
                begin
                    sender_idle_pct    = 47;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 47;
                end
                default:
                begin
                    sender_idle_pct    = 27;
                    receiver_stall_pct = 27;
                end
            endcase
            run_random(WORDS_PER_PHASE);
        end
        item_ch.valid <= 1'b0;

        // drain, then allow for stray words
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("nearest_point_search_core_test passed");
        else
            $display("nearest_point_search_core_test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/nps_pkg.sv
rtl/core/nps_stream_if.sv
rtl/core/nps_point_mem.sv
rtl/core/nps_dist_unit.sv
rtl/core/nearest_point_search_core.sv
rtl/core/nps_checker.sv
tb/sv/nearest_point_checker.sv
tb/sv/nearest_point_search_core_test.sv
